// File: hw/rtl/salru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg
// Shared geometry, codes and control structs of the LRU write-back cache.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 16;
  localparam int ADDR_BITS  = 32;

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int SET_W   = $clog2(SETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W   = ADDR_BITS - OFF_W - SET_W;
  localparam int LINES   = SETS * WAYS;
  localparam int LINE_W  = SET_W + WAY_W;
  localparam int DADDR_W = LINE_W + OFF_W;
  localparam int STAMP_W = 32;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FILL  = 2'd2
  } cmd_code_e;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_WB       = 2'd1,
    KIND_FILL_REQ = 2'd2,
    KIND_REJECT   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESP,
    ST_WB_RD,
    ST_WB_OUT,
    ST_REQ
  } state_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_RESP,
    EMIT_WB,
    EMIT_REQ
  } emit_e;

  typedef struct packed {
    logic  accept;
    logic  lookup;
    logic  wb_read;
    emit_e emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_access;
    logic hit;
    logic victim_dirty;
    logic wb_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// File: hw/rtl/salru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_ctrl
// Sequencer for lookup, response, write-back and fill request phases.
// ----------------------------------------------------------------------------
module salru_ctrl import salru_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == ST_IDLE) && !sts_i.out_busy);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.is_access) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts_i.hit)               state_d = ST_RESP;
        else if (sts_i.victim_dirty) state_d = ST_WB_RD;
        else                         state_d = ST_REQ;
      end
      ST_RESP: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      ST_WB_RD: begin
        state_d = ST_WB_OUT;
      end
      ST_WB_OUT: begin
        if (!sts_i.out_busy) state_d = sts_i.wb_last ? ST_REQ : ST_WB_RD;
      end
      ST_REQ: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.emit    = EMIT_NONE;
    cmd_o.accept  = accept;
    unique case (state_q)
      ST_IDLE:   ;
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_RESP: begin
        if (!sts_i.out_busy) cmd_o.emit = EMIT_RESP;
      end
      ST_WB_RD:  cmd_o.wb_read = 1'b1;
      ST_WB_OUT: begin
        if (!sts_i.out_busy) cmd_o.emit = EMIT_WB;
      end
      ST_REQ: begin
        if (!sts_i.out_busy) cmd_o.emit = EMIT_REQ;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/salru_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_dpath
// Tag, stamp and data arrays, line state flags, miss bookkeeping, result reg.
// ----------------------------------------------------------------------------
module salru_dpath import salru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output ctrl_sts_t   sts_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  fill_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] mem_address_o,
  output logic [7:0]  data_byte_o,
  output logic        hit_o,
  output logic        last_o
);

  // line state flags, cleared by reset
  logic [LINES-1:0] valid_q, dirty_q;

  // arrays (no reset needed: only read for valid lines)
  logic [TAG_W-1:0]   tag_mem   [WAYS][SETS];
  logic [STAMP_W-1:0] stamp_mem [WAYS][SETS];
  logic [7:0]         data_mem  [LINES*LINE_BYTES];

  logic [TAG_W-1:0]   tag_rd_q   [WAYS];
  logic [STAMP_W-1:0] stamp_rd_q [WAYS];
  logic [7:0]         rdata_q;

  logic [STAMP_W-1:0] clock_q;
  logic               waiting_q;
  logic               pend_write_q;
  logic [7:0]         pend_byte_q;
  logic [OFF_W-1:0]   off_q;
  logic [SET_W-1:0]   set_q;
  logic [TAG_W-1:0]   tag_q;
  logic [OFF_W-1:0]   fill_cnt_q;
  logic [OFF_W-1:0]   wb_cnt_q;
  logic [WAY_W-1:0]   victim_q;
  logic [TAG_W-1:0]   vtag_q;

  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic [31:0]        addr_q;
  logic [7:0]         data_q;
  logic               hit_q;
  logic               last_q;

  logic [ADDR_BITS-1:0] a_in;
  logic [SET_W-1:0]     in_set;
  logic                 in_is_rw, in_is_fill, is_access, reject;
  logic                 fill_take, fill_done, fill_at_off;

  logic [WAYS-1:0]  hit_vec;
  logic             hit_any;
  logic [WAY_W-1:0] hit_way, vic_way, use_way;
  logic             vic_found;
  logic [LINE_W-1:0] vic_line, use_line;

  logic               mem_we, mem_re;
  logic [DADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata;

  logic               load_out;
  logic [1:0]         kind_d;
  logic [31:0]        addr_d;
  logic [7:0]         data_d;
  logic               hit_d, last_d;
  logic [ADDR_BITS-1:0] line_addr;

  assign a_in       = address_i[ADDR_BITS-1:0];
  assign in_set     = a_in[OFF_W +: SET_W];
  assign in_is_rw   = (command_i == CMD_READ) || (command_i == CMD_WRITE);
  assign in_is_fill = (command_i == CMD_FILL);
  assign is_access  = in_is_rw && !waiting_q;
  assign reject     = !is_access && !(in_is_fill && waiting_q);
  assign fill_take  = cmd_i.accept && in_is_fill && waiting_q;
  assign fill_done  = fill_take && (fill_cnt_q == OFF_W'(LINE_BYTES - 1));
  assign fill_at_off = (fill_cnt_q == off_q);

  // way compare and victim choice
  always_comb begin
    hit_way   = '0;
    hit_any   = 1'b0;
    vic_way   = '0;
    vic_found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_q[{set_q, WAY_W'(w)}] && (tag_rd_q[w] == tag_q);
      if (hit_vec[w] && !hit_any) begin
        hit_way = WAY_W'(w);
        hit_any = 1'b1;
      end
      if (!valid_q[{set_q, WAY_W'(w)}] && !vic_found) begin
        vic_way   = WAY_W'(w);
        vic_found = 1'b1;
      end
    end
    if (!vic_found) begin
      for (int w = 1; w < WAYS; w++) begin
        if (stamp_rd_q[w] < stamp_rd_q[vic_way]) vic_way = WAY_W'(w);
      end
    end
  end

  assign vic_line = {set_q, vic_way};
  assign use_way  = hit_any ? hit_way : vic_way;
  assign use_line = {set_q, use_way};

  assign sts_o.is_access    = is_access;
  assign sts_o.hit          = hit_any;
  assign sts_o.victim_dirty = valid_q[vic_line] && dirty_q[vic_line];
  assign sts_o.wb_last      = (wb_cnt_q == OFF_W'(LINE_BYTES - 1));
  assign sts_o.out_busy     = out_valid_q && out_stall_i;

  // data array port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {set_q, victim_q, fill_cnt_q};
    mem_wdata = (pend_write_q && fill_at_off) ? pend_byte_q : fill_data_i;
    mem_re    = 1'b0;
    mem_raddr = {set_q, victim_q, wb_cnt_q};
    if (fill_take) begin
      mem_we = 1'b1;
    end else if (cmd_i.lookup && hit_any && pend_write_q) begin
      mem_we    = 1'b1;
      mem_waddr = {set_q, hit_way, off_q};
      mem_wdata = pend_byte_q;
    end
    if (cmd_i.lookup && hit_any && !pend_write_q) begin
      mem_re    = 1'b1;
      mem_raddr = {set_q, hit_way, off_q};
    end else if (cmd_i.wb_read) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) data_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= data_mem[mem_raddr];
  end

  // tag and stamp arrays: read whole set on read/write accept; stamp on lookup, tag on fill end
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_access) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_rd_q[w]   <= tag_mem[w][in_set];
        stamp_rd_q[w] <= stamp_mem[w][in_set];
      end
    end
    if (cmd_i.lookup) stamp_mem[use_way][set_q] <= clock_q;
    if (fill_done)    tag_mem[victim_q][set_q]  <= tag_q;
  end

  // miss bookkeeping and line flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      dirty_q      <= '0;
      clock_q      <= '0;
      waiting_q    <= 1'b0;
      pend_write_q <= 1'b0;
      pend_byte_q  <= '0;
      off_q        <= '0;
      set_q        <= '0;
      tag_q        <= '0;
      fill_cnt_q   <= '0;
      wb_cnt_q     <= '0;
      victim_q     <= '0;
      vtag_q       <= '0;
    end else begin
      if (cmd_i.accept && is_access) begin
        clock_q      <= clock_q + 1'b1;
        pend_write_q <= (command_i == CMD_WRITE);
        pend_byte_q  <= (command_i == CMD_WRITE) ? write_data_i : 8'd0;
        off_q        <= a_in[OFF_W-1:0];
        set_q        <= in_set;
        tag_q        <= a_in[ADDR_BITS-1 -: TAG_W];
      end
      if (cmd_i.lookup) begin
        if (hit_any) begin
          if (pend_write_q) dirty_q[use_line] <= 1'b1;
        end else begin
          victim_q          <= vic_way;
          vtag_q            <= tag_rd_q[vic_way];
          valid_q[vic_line] <= 1'b0;
          dirty_q[vic_line] <= 1'b0;
          waiting_q         <= 1'b1;
          fill_cnt_q        <= '0;
          wb_cnt_q          <= '0;
        end
      end
      if (cmd_i.emit == EMIT_WB) wb_cnt_q <= wb_cnt_q + 1'b1;
      if (fill_take) begin
        if (!pend_write_q && fill_at_off) pend_byte_q <= fill_data_i;
        fill_cnt_q <= fill_cnt_q + 1'b1;
        if (fill_done) begin
          valid_q[{set_q, victim_q}] <= 1'b1;
          dirty_q[{set_q, victim_q}] <= pend_write_q;
          waiting_q                  <= 1'b0;
          fill_cnt_q                 <= '0;
        end
      end
    end
  end

  // result selection
  assign line_addr = {tag_q, set_q, {OFF_W{1'b0}}};

  always_comb begin
    load_out = 1'b0;
    kind_d   = KIND_DONE;
    addr_d   = '0;
    data_d   = '0;
    hit_d    = 1'b0;
    last_d   = 1'b1;
    if (cmd_i.accept && reject) begin
      load_out = 1'b1;
      kind_d   = KIND_REJECT;
    end else if (fill_done) begin
      load_out = 1'b1;
      if (!pend_write_q) data_d = fill_at_off ? fill_data_i : pend_byte_q;
    end else begin
      case (cmd_i.emit)
        EMIT_RESP: begin
          load_out = 1'b1;
          hit_d    = 1'b1;
          data_d   = pend_write_q ? 8'd0 : rdata_q;
        end
        EMIT_WB: begin
          load_out = 1'b1;
          kind_d   = KIND_WB;
          addr_d   = 32'({vtag_q, set_q, wb_cnt_q});
          data_d   = rdata_q;
          last_d   = 1'b0;
        end
        EMIT_REQ: begin
          load_out = 1'b1;
          kind_d   = KIND_FILL_REQ;
          addr_d   = 32'(line_addr);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      kind_q <= kind_d;
      addr_q <= addr_d;
      data_q <= data_d;
      hit_q  <= hit_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign mem_address_o = addr_q;
  assign data_byte_o   = data_q;
  assign hit_o         = hit_q;
  assign last_o        = last_q;

  // a tag can sit in only one valid way of a set
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |-> $onehot0(hit_vec))
    else $error("multiple ways hit");

  // fill counter only advances while a line fill is outstanding
  a_fill_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_cnt_q != '0) |-> waiting_q)
    else $error("fill count without pending fill");

  // last fill byte closes the miss
  a_fill_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |=> (!waiting_q && out_valid_q))
    else $error("fill completion missed");

  // a result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("result overwritten");

endmodule

// File: hw/rtl/set_assoc_writeback_lru_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache
// Set-associative write-back, write-allocate byte cache with LRU by stamps.
// ----------------------------------------------------------------------------
// 64 sets x 4 ways x 16-byte lines. One request is in flight at a time. A
// read or write hit goes through a tag/stamp set read, compare and data
// array access, and the result register, which waits while the output
// is held. A miss picks the lowest invalid way or else the oldest stamp,
// writes a dirty victim back as 16 byte results (each a data array read,
// then the result register), then issues one line fill request. While
// the fill is outstanding, read/write requests are rejected; each fill
// byte is written to the data array as it is taken, and the last one
// produces the access-done result. Stray fill bytes and command code 3
// are rejected. All results leave through one output register, and a
// new request is taken in the cycle the previous result is consumed.
// ----------------------------------------------------------------------------
module set_assoc_writeback_lru_cache import salru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  fill_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] mem_address_o,
  output logic [7:0]  data_byte_o,
  output logic        hit_o,
  output logic        last_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: owns the input handshake and the phase of the request
  salru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arrays, line flags, miss state and the result register
  salru_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .fill_data_i   (fill_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .mem_address_o (mem_address_o),
    .data_byte_o   (data_byte_o),
    .hit_o         (hit_o),
    .last_o        (last_o)
  );

endmodule
